@@ design/gbba_pkg.sv @@
package gbba_pkg;

  localparam int MAX_GROUPS  = 16;
  localparam int MAX_BPG     = 8192;
  localparam int WORD_W      = 32;
  localparam int BM_DEPTH    = MAX_GROUPS * MAX_BPG / WORD_W;
  localparam int GRP_W       = $clog2(MAX_GROUPS);
  localparam int GCNT_W      = $clog2(MAX_GROUPS + 1);
  localparam int WPG_W       = $clog2(MAX_BPG / WORD_W);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int IDX_W       = $clog2(MAX_BPG);
  localparam int BM_AW       = GRP_W + WPG_W;
  localparam int BPG_W       = 14;
  localparam int BLK_W       = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef struct packed {
    logic             done;
    logic             oor;
    logic [GRP_W-1:0] quot;
    logic [BPG_W-1:0] rem;
  } div_res_t;

endpackage

@@ design/gbba_ram.sv @@
module gbba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gbba_grp_div.sv @@
module gbba_grp_div import gbba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BLK_W-1:0]  dividend_i,
  input  logic [BPG_W-1:0]  divisor_i,
  input  logic [GCNT_W-1:0] limit_i,
  output div_res_t          res_o
);

  logic              busy_q;
  logic [BLK_W-1:0]  rem_q;
  logic [BPG_W-1:0]  div_q;
  logic [GCNT_W-1:0] lim_q;
  logic [GRP_W-1:0]  cnt_q;
  logic              fits;
  logic              at_lim;

  // one compare and subtract per cycle; quotient bounded by the limit
  always_comb begin
    fits       = rem_q < BLK_W'(div_q);
    at_lim     = GCNT_W'(cnt_q) == (lim_q - 1'b1);
    res_o.done = busy_q && (fits || at_lim);
    res_o.oor  = !fits;
    res_o.quot = cnt_q;
    res_o.rem  = rem_q[BPG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (res_o.done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      div_q <= divisor_i;
      lim_q <= limit_i;
      cnt_q <= '0;
    end else if (busy_q && !res_o.done) begin
      rem_q <= rem_q - BLK_W'(div_q);
      cnt_q <= cnt_q + 1'b1;
    end
  end

endmodule

@@ design/grouped_block_bitmap_allocator.sv @@
// Allocate: a division finds the start group, then each group visited is checked and its
//   bitmap words are read (one word per cycle from the bitmap RAM), then the result is registered.
// Free: group division, one bitmap read and, if the block was in use, one write-back.
// One request in flight; the next beat is taken in the cycle after the result is registered.
// Reset: counts clear at once; all 4096 words of the bitmap RAM are swept to zero,
//   during which no request beat is taken (configuration writes are).
module grouped_block_bitmap_allocator import gbba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [3:0]            prefer_group_i,
  input  logic [BLK_W-1:0]      free_block_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BLK_W-1:0]      block_number_o,
  output logic [1:0]            status_o,
  output logic [BLK_W-1:0]      used_total_o
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_GCHK = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_FRD  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!w[j]) r = BIT_W'(j);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [4:0]        gc_q;
  logic [BPG_W-1:0]  bpg_q;
  logic              fdb_q;
  logic [GCNT_W-1:0] ng;
  logic [BPG_W-1:0]  bpg;

  logic [BPG_W-1:0]  gused_q [MAX_GROUPS];
  logic [BLK_W-1:0]  total_q;
  logic [BM_AW-1:0]  clr_q;

  logic              req_free_q, req_free_d;
  logic [GRP_W-1:0]  g_q, g_d;
  logic [GCNT_W-1:0] k_q, k_d;
  logic [WPG_W-1:0]  w_q, w_d;
  logic [BLK_W-1:0]  base_q, base_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [BM_AW-1:0]  addr_q, addr_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [WORD_W-1:0] wdata_q, wdata_d;
  logic              wr_pend_q, wr_pend_d;
  op_e               op_q, op_d;
  status_e           stat_q, stat_d;

  logic              out_valid_q;
  logic [BLK_W-1:0]  out_blk_q;
  status_e           out_stat_q;
  logic [BLK_W-1:0]  out_total_q;

  logic              in_fire;
  logic              fin_go;
  logic              div_start;
  logic [BLK_W-1:0]  div_dividend;
  logic [BPG_W-1:0]  div_divisor;
  logic [GCNT_W-1:0] div_limit;
  div_res_t          div_res;

  logic              ram_we;
  logic              ram_re;
  logic [BM_AW-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic [BPG_W-1:0]  rem_bits;
  logic [WORD_W-1:0] vmask;
  logic [WORD_W-1:0] scan_word;
  logic              scan_hit;
  logic [BIT_W-1:0]  scan_j;
  logic              last_word;
  logic              grp_full;
  logic [GRP_W-1:0]  g_next;
  logic              visit_done;
  logic [BLK_W-1:0]  total_d;

  always_comb begin
    if (gc_q == '0) ng = GCNT_W'(1);
    else if (gc_q > 5'(MAX_GROUPS)) ng = GCNT_W'(MAX_GROUPS);
    else ng = GCNT_W'(gc_q);
    if (bpg_q < BPG_W'(8)) bpg = BPG_W'(8);
    else if (bpg_q > BPG_W'(MAX_BPG)) bpg = BPG_W'(MAX_BPG);
    else bpg = bpg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q  <= 5'(MAX_GROUPS);
      bpg_q <= BPG_W'(MAX_BPG);
      fdb_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_COUNT:      gc_q  <= cfg_wdata_i[4:0];
        CFG_BLOCKS_PER_GROUP: bpg_q <= cfg_wdata_i[BPG_W-1:0];
        CFG_FIRST_DATA_BLOCK: fdb_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // start group = prefer mod group count; free block splits into group and index
  always_comb begin
    div_start = in_fire && !(req_type_i == REQ_FREE && free_block_i < BLK_W'(fdb_q));
    if (req_type_i == REQ_FREE) begin
      div_dividend = free_block_i - BLK_W'(fdb_q);
      div_divisor  = bpg;
      div_limit    = ng;
    end else begin
      div_dividend = BLK_W'(prefer_group_i);
      div_divisor  = BPG_W'(ng);
      div_limit    = GCNT_W'(MAX_GROUPS);
    end
  end

  gbba_grp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .limit_i    (div_limit),
    .res_o      (div_res)
  );

  always_comb begin
    rem_bits = bpg - BPG_W'({w_q, BIT_W'(0)});
    for (int j = 0; j < WORD_W; j++) begin
      vmask[j] = BPG_W'(j) < rem_bits;
    end
    scan_word  = ram_rdata | ~vmask;
    scan_hit   = ~&scan_word;
    scan_j     = low_zero(scan_word);
    last_word  = rem_bits <= BPG_W'(WORD_W);
    grp_full   = gused_q[g_q] >= bpg;
    g_next     = (GCNT_W'(g_q) + 1'b1 == ng) ? '0 : g_q + 1'b1;
    visit_done = (k_q + 1'b1) == ng;
  end

  always_comb begin
    state_d    = state_q;
    req_free_d = req_free_q;
    g_d        = g_q;
    k_d        = k_q;
    w_d        = w_q;
    base_d     = base_q;
    blk_d      = blk_q;
    addr_d     = addr_q;
    bit_d      = bit_q;
    wdata_d    = wdata_q;
    wr_pend_d  = wr_pend_q;
    op_d       = op_q;
    stat_d     = stat_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = addr_q;
    ram_wdata  = wdata_q;

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        if (clr_q == BM_AW'(BM_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          req_free_d = req_type_i;
          blk_d      = '0;
          wr_pend_d  = 1'b0;
          op_d       = OP_NONE;
          stat_d     = STAT_OK;
          if (div_start) begin
            state_d = S_DIV;
          end else begin
            stat_d  = STAT_RANGE;
            state_d = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (req_free_q == REQ_FREE) begin
            if (div_res.oor) begin
              stat_d  = STAT_RANGE;
              state_d = S_FIN;
            end else begin
              g_d      = div_res.quot;
              addr_d   = {div_res.quot, div_res.rem[IDX_W-1:BIT_W]};
              bit_d    = div_res.rem[BIT_W-1:0];
              ram_re   = 1'b1;
              ram_addr = {div_res.quot, div_res.rem[IDX_W-1:BIT_W]};
              state_d  = S_FRD;
            end
          end else begin
            g_d     = div_res.rem[GRP_W-1:0];
            k_d     = '0;
            state_d = S_GCHK;
          end
        end
      end
      S_GCHK: begin
        if (grp_full) begin
          g_d = g_next;
          k_d = k_q + 1'b1;
          if (visit_done) begin
            stat_d  = STAT_FULL;
            state_d = S_FIN;
          end
        end else begin
          ram_re   = 1'b1;
          ram_addr = {g_q, WPG_W'(0)};
          w_d      = '0;
          base_d   = BLK_W'(fdb_q) + BLK_W'(g_q) * BLK_W'(bpg);
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          blk_d     = base_q + BLK_W'({w_q, scan_j});
          addr_d    = {g_q, w_q};
          wdata_d   = ram_rdata | (WORD_W'(1) << scan_j);
          wr_pend_d = 1'b1;
          op_d      = OP_ALLOC;
          state_d   = S_FIN;
        end else if (last_word) begin
          g_d = g_next;
          k_d = k_q + 1'b1;
          if (visit_done) begin
            stat_d  = STAT_FULL;
            state_d = S_FIN;
          end else begin
            state_d = S_GCHK;
          end
        end else begin
          w_d      = w_q + 1'b1;
          ram_re   = 1'b1;
          ram_addr = {g_q, WPG_W'(w_q + 1'b1)};
        end
      end
      S_FRD: begin
        if (!ram_rdata[bit_q]) begin
          stat_d = STAT_NOT_USED;
        end else begin
          wdata_d   = ram_rdata & ~(WORD_W'(1) << bit_q);
          wr_pend_d = 1'b1;
          op_d      = OP_FREE;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          ram_we  = wr_pend_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ALLOC: total_d = total_q + 1'b1;
      OP_FREE:  total_d = total_q - 1'b1;
      default:  total_d = total_q;
    endcase
  end

  gbba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BM_DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        gused_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (fin_go) begin
        out_valid_q <= 1'b1;
        total_q     <= total_d;
        case (op_q)
          OP_ALLOC: gused_q[g_q] <= gused_q[g_q] + 1'b1;
          OP_FREE:  gused_q[g_q] <= gused_q[g_q] - 1'b1;
          default: ;
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_free_q <= req_free_d;
    g_q        <= g_d;
    k_q        <= k_d;
    w_q        <= w_d;
    base_q     <= base_d;
    blk_q      <= blk_d;
    addr_q     <= addr_d;
    bit_q      <= bit_d;
    wdata_q    <= wdata_d;
    wr_pend_q  <= wr_pend_d;
    op_q       <= op_d;
    stat_q     <= stat_d;
    if (fin_go) begin
      out_blk_q   <= blk_q;
      out_stat_q  <= stat_q;
      out_total_q <= total_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_blk_q;
  assign status_o       = out_stat_q;
  assign used_total_o   = out_total_q;

`ifndef NO_ASSERTIONS
  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> block_number_o == '0)
    else $error("failed request carries a block number");

  a_ram_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_CLR || state_q == S_FIN)
    else $error("bitmap written outside clear or write-back");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && op_q == OP_ALLOC |=> total_q == $past(total_q) + 1'b1)
    else $error("total not bumped on allocation");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while a request is in flight");
`endif

endmodule

@@ sim/tb_grouped_block_bitmap_allocator.sv @@
`timescale 1ns / 100ps

module tb_grouped_block_bitmap_allocator import gbba_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [BLK_W-1:0] blk;
    status_e          st;
    logic [BLK_W-1:0] total;
  } reply_t;

  // Shadow of the allocator: bitmap, counts and geometry, plus the replies still owed.
  class block_ledger;
    bit               used_map [MAX_GROUPS*MAX_BPG];
    logic [BPG_W-1:0] grp_used [MAX_GROUPS];
    logic [BLK_W-1:0] total_used;
    logic [4:0]       cfg_groups;
    logic [BPG_W-1:0] cfg_bpg;
    logic             cfg_fdb;
    int unsigned      live_addrs [$];
    logic [BLK_W-1:0] last_freed;
    reply_t           pending [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      requests;
    int unsigned      frees_ok;
    int unsigned      stat_seen [4];

    function new();
      cfg_groups = 5'd16;
      cfg_bpg    = 14'd8192;
      cfg_fdb    = 1'b1;
      total_used = '0;
      last_freed = '0;
      foreach (grp_used[g]) grp_used[g] = '0;
      foreach (stat_seen[s]) stat_seen[s] = 0;
      errors = 0; checked = 0; requests = 0; frees_ok = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GROUP_COUNT:      cfg_groups = val[4:0];
        CFG_BLOCKS_PER_GROUP: cfg_bpg    = val;
        CFG_FIRST_DATA_BLOCK: cfg_fdb    = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_groups();
      if (cfg_groups == 0) return 1;
      if (cfg_groups > MAX_GROUPS) return MAX_GROUPS;
      return cfg_groups;
    endfunction

    function int unsigned eff_bpg();
      if (cfg_bpg < 8) return 8;
      if (cfg_bpg > MAX_BPG) return MAX_BPG;
      return cfg_bpg;
    endfunction

    function int unsigned end_block();
      return cfg_fdb + eff_groups() * eff_bpg();
    endfunction

    // Block number of a random block in use, if it still maps into the current geometry.
    function bit pick_live(output logic [BLK_W-1:0] blk);
      int unsigned a, g, i;
      blk = '0;
      if (live_addrs.size() == 0) return 0;
      a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      g = a / MAX_BPG;
      i = a % MAX_BPG;
      if (g >= eff_groups() || i >= eff_bpg()) return 0;
      blk = BLK_W'(cfg_fdb + g * eff_bpg() + i);
      return 1;
    endfunction

    function void log_request(logic rt, logic [3:0] pg, logic [BLK_W-1:0] fb);
      reply_t      r;
      int unsigned ng, bpg, fdb, pref, k, g, i, a, b, off;
      bit          found;
      ng  = eff_groups();
      bpg = eff_bpg();
      fdb = cfg_fdb;
      r.blk = '0;
      r.st  = STAT_OK;
      if (rt == REQ_ALLOC) begin
        pref  = pg;
        found = 0;
        for (k = 0; k < ng && !found; k++) begin
          g = (pref + k) % ng;
          if (grp_used[g] < bpg) begin
            for (i = 0; i < bpg && !found; i++) begin
              a = g * MAX_BPG + i;
              if (!used_map[a]) begin
                used_map[a] = 1'b1;
                grp_used[g] = grp_used[g] + 1'b1;
                total_used  = total_used + 1'b1;
                live_addrs.push_back(a);
                r.blk = BLK_W'(fdb + g * bpg + i);
                found = 1;
              end
            end
          end
        end
        if (!found) r.st = STAT_FULL;
      end else begin
        b = fb;
        if (b < fdb) begin
          r.st = STAT_RANGE;
        end else begin
          off = b - fdb;
          g   = off / bpg;
          i   = off % bpg;
          if (g >= ng) begin
            r.st = STAT_RANGE;
          end else begin
            a = g * MAX_BPG + i;
            if (!used_map[a]) begin
              r.st = STAT_NOT_USED;
            end else begin
              used_map[a] = 1'b0;
              grp_used[g] = grp_used[g] - 1'b1;
              total_used  = total_used - 1'b1;
              last_freed  = fb;
              frees_ok++;
              foreach (live_addrs[j]) begin
                if (live_addrs[j] == a) begin
                  live_addrs.delete(j);
                  break;
                end
              end
            end
          end
        end
      end
      r.total = total_used;
      stat_seen[r.st]++;
      requests++;
      pending.push_back(r);
    endfunction

    function void check_reply(logic [BLK_W-1:0] blk, logic [1:0] st, logic [BLK_W-1:0] tot);
      reply_t r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply with nothing owed: blk %0d st %0d total %0d", $time, blk, st, tot);
        return;
      end
      r = pending.pop_front();
      checked++;
      if (blk !== r.blk || st !== r.st || tot !== r.total) begin
        errors++;
        if (errors <= 10)
          $display("%0t: reply %0d mismatch: blk %0d/%0d st %0d/%0d total %0d/%0d (exp/act)",
                   $time, checked, r.blk, blk, r.st, st, r.total, tot);
      end
    endfunction
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i     = REQ_ALLOC;
  logic [3:0]            prefer_group_i = '0;
  logic [BLK_W-1:0]      free_block_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [BLK_W-1:0]      block_number_o;
  logic [1:0]            status_o;
  logic [BLK_W-1:0]      used_total_o;

  block_ledger ledger = new();
  bit          hold_off_req = 1'b0;
  int unsigned geometries   = 0;

  grouped_block_bitmap_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .prefer_group_i (prefer_group_i),
    .free_block_i   (free_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_number_o (block_number_o),
    .status_o       (status_o),
    .used_total_o   (used_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      ledger.check_reply(block_number_o, status_o, used_total_o);
  end

  always @(posedge clk_i) begin : watchdog
    static int unsigned stall_cycles = 0;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random ready segments, plus a long hold-off on request.
  initial begin : rx_proc
    int unsigned mode, span, pat, j;
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 60);
        pat  = $urandom;
        for (j = 0; j < span; j++) begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= pat[j % 32];
            2:       out_ready_i <= ($urandom_range(0, 3) != 0);
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_req(input logic rt, input logic [3:0] pg, input logic [BLK_W-1:0] fb);
    in_valid_i     <= 1'b1;
    req_type_i     <= rt;
    prefer_group_i <= pg;
    free_block_i   <= fb;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.log_request(rt, pg, fb);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.pending.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_geometry(input logic [4:0] gc, input logic [BPG_W-1:0] bpg,
                                  input logic fdb, input bit spare);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] data [4];
    int unsigned           k, first;
    idx[0] = CFG_SPARE;            data[0] = CFG_DATA_W'($urandom);
    idx[1] = CFG_GROUP_COUNT;      data[1] = {9'($urandom), gc};
    idx[2] = CFG_BLOCKS_PER_GROUP; data[2] = bpg;
    idx[3] = CFG_FIRST_DATA_BLOCK; data[3] = {13'($urandom), fdb};
    first = spare ? 0 : 1;
    for (k = first; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[k];
      cfg_wdata_i <= data[k];
      @(posedge clk_i);
      ledger.set_reg(idx[k], data[k]);
    end
    cfg_we_i <= 1'b0;
    geometries++;
    @(posedge clk_i);
  endtask

  // Mostly allocations and frees of blocks in use; the rest out-of-range, edge and double frees.
  task automatic pick_item(input int unsigned alloc_pct, output logic rt,
                           output logic [3:0] pg, output logic [BLK_W-1:0] fb);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    pg   = 4'($urandom_range(0, 15));
    fb   = BLK_W'($urandom_range(0, 262143));
    if (roll < alloc_pct) begin
      rt = REQ_ALLOC;
    end else begin
      rt = REQ_FREE;
      if (roll >= 90 || !ledger.pick_live(fb)) begin
        case ($urandom_range(0, 4))
          0:       fb = BLK_W'($urandom_range(0, 262143));
          1:       fb = BLK_W'(ledger.cfg_fdb - 1);
          2:       fb = BLK_W'(ledger.end_block());
          3:       fb = BLK_W'(ledger.end_block() - 1);
          default: fb = ledger.last_freed;
        endcase
      end
    end
  endtask

  initial begin : main_proc
    int unsigned      ph_groups [NUM_PHASES] = '{2, 0, 5, 16, 3, 31, 1, 16};
    int unsigned      ph_bpg    [NUM_PHASES] = '{8, 3, 13, 8, 40, 16383, 9, 8192};
    int unsigned      ph_fdb    [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1};
    int unsigned      ph_items  [NUM_PHASES] = '{80, 60, 80, 90, 80, 40, 60, 60};
    int unsigned      ph_alloc  [NUM_PHASES] = '{60, 60, 55, 65, 55, 60, 60, 55};
    int unsigned      p, n, k, burst_left;
    logic             rt;
    logic [3:0]       pg;
    logic [BLK_W-1:0] fb;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: ends of the group range, edges of the block range, double free.
    send_req(REQ_ALLOC, 4'd0,  18'h3FFFF);
    send_req(REQ_ALLOC, 4'd15, '0);
    send_req(REQ_ALLOC, 4'd15, 18'h2AAAA);
    send_req(REQ_FREE,  4'd7,  18'd0);
    send_req(REQ_FREE,  4'd8,  18'h3FFFF);
    send_req(REQ_FREE,  4'd0,  18'd131072);
    send_req(REQ_FREE,  4'd15, 18'd131073);
    send_req(REQ_FREE,  4'd3,  18'd1);
    send_req(REQ_FREE,  4'd12, 18'd1);
    send_req(REQ_FREE,  4'd5,  18'd122881);
    drain();

    // Single tiny group: fill it, run out, free past the end, reuse.
    program_geometry(5'd1, 14'd8, 1'b0, 1'b0);
    for (k = 0; k < 9; k++)
      send_req(REQ_ALLOC, (k == 0) ? 4'hF : 4'(k), 18'h15555);
    send_req(REQ_FREE,  4'd0, 18'd8);
    send_req(REQ_FREE,  4'd1, 18'd7);
    send_req(REQ_ALLOC, 4'd9, 18'd0);
    drain();

    burst_left = 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      program_geometry(5'(ph_groups[p]), BPG_W'(ph_bpg[p]), ph_fdb[p][0], p == 1);
      for (n = 0; n < ph_items[p]; n++) begin
        if (burst_left == 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pick_item(ph_alloc[p], rt, pg, fb);
        send_req(rt, pg, fb);
        if (p == 2 && n == 20) hold_off_req = 1'b1;
        if (p == 0 && n == 40) begin
          in_valid_i <= 1'b0;
          while (ledger.pending.size() > 0) @(posedge clk_i);
        end
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Run covered %0d requests over %0d geometries: %0d granted, %0d full, %0d freed",
             ledger.requests, geometries, ledger.stat_seen[STAT_OK] - ledger.frees_ok,
             ledger.stat_seen[STAT_FULL], ledger.frees_ok);
    $display("Flagged frees: %0d out of range, %0d already free; %0d replies checked",
             ledger.stat_seen[STAT_RANGE], ledger.stat_seen[STAT_NOT_USED], ledger.checked);
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", ledger.errors, ledger.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
